// ----- rtl/y86_pkg.sv -----
// ----------------------------------------------------------------------------
// y86_pkg
// Shared constants and types for the Y86-64 ALU execute unit: register file
// geometry, operation codes, status codes and divider sizing.
// ----------------------------------------------------------------------------
package y86_pkg;

    // Register file geometry
    localparam int REG_COUNT  = 16;
    localparam int REG_IDX_W  = 4;
    localparam int REG_ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W + 1)'(REG_COUNT);

    // Data path width
    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;

    // Operation codes carried by func
    localparam logic [3:0] OP_ADD = 4'h0;
    localparam logic [3:0] OP_SUB = 4'h1;
    localparam logic [3:0] OP_AND = 4'h2;
    localparam logic [3:0] OP_XOR = 4'h3;
    localparam logic [3:0] OP_MUL = 4'h4;
    localparam logic [3:0] OP_DIV = 4'h5;
    localparam logic [3:0] OP_MOD = 4'h6;

    // Completion status of one transaction
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ----- rtl/y86_divider.sv -----
// ----------------------------------------------------------------------------
// y86_divider
// Restoring radix-2 unsigned divider. One quotient bit per cycle; done pulses
// for one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module y86_divider
    import y86_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    dvs_reg;

    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;
    logic                 fits;

    // Shift in the next dividend bit and try a subtraction
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = !trial[DATA_W];

    // Control: busy window and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/y86_alu_execute_unit.sv -----
// ----------------------------------------------------------------------------
// y86_alu_execute_unit
// Y86-64 ALU execute stage with register file, condition codes and PC.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. After acceptance the register file
// (a synchronous two-read, one-write memory) is read, operands are staged,
// and the operation runs. Add, subtract, and, xor, invalid codes and preload
// go straight from execute to finish. Multiply sums the partial products
// low*low, low*high and high*low from one shared 32x32 multiplier. Divide
// and modulo run the bit-serial divider between staging, start and handoff;
// divide by zero skips the divider. The next transaction is accepted the
// cycle after a result is loaded into the output register, even if that
// result is still stalled.
// Register file contents read as zero until written after reset.
// ----------------------------------------------------------------------------
module y86_alu_execute_unit
    import y86_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        func,
    input  logic [3:0]        reg_a,
    input  logic [3:0]        reg_b,
    input  logic [63:0]       next_pc,
    input  logic              preload,
    input  logic [63:0]       imm_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       result_value,
    output logic              zero_flag,
    output logic              sign_flag,
    output logic [63:0]       pc_value,
    output logic [1:0]        status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    logic                   cc_zero_reg;
    logic                   cc_sign_reg;
    logic [DATA_W-1:0]      pc_reg;
    logic [REG_COUNT-1:0]   valid_bits_reg;
    logic                   div_start_reg;
    logic [1:0]             mul_step_reg;

    // Register file storage
    logic [DATA_W-1:0]      rf_mem [REG_COUNT];
    logic [DATA_W-1:0]      rd_a_reg;
    logic [DATA_W-1:0]      rd_b_reg;
    logic                   a_ok_reg;
    logic                   b_ok_reg;

    // Captured transaction fields
    logic [3:0]             func_reg;
    logic [REG_IDX_W-1:0]   rb_reg;
    logic                   rb_in_reg;
    logic [DATA_W-1:0]      npc_reg;
    logic                   pre_reg;
    logic [DATA_W-1:0]      imm_reg;

    // Operands and results
    logic [DATA_W-1:0]      va_reg;
    logic [DATA_W-1:0]      vb_reg;
    logic [DATA_W-1:0]      res_reg;
    status_t                st_reg;
    logic [DATA_W-1:0]      mul_acc_reg;
    logic [DATA_W-1:0]      mul_prod_reg;
    logic [DATA_W-1:0]      result_value_reg;
    status_t                status_out_reg;

    logic                   accept;
    logic                   fin_go;
    logic                   a_in_range;
    logic                   b_in_range;
    logic [REG_ADDR_W-1:0]  addr_a;
    logic [REG_ADDR_W-1:0]  addr_b;
    logic [REG_ADDR_W-1:0]  wr_addr;
    logic                   wr_en;
    logic                   res_ok;
    logic [HALF_W-1:0]      mul_x;
    logic [HALF_W-1:0]      mul_y;
    logic [DATA_W-1:0]      mul_p;
    logic [DATA_W-1:0]      mul_sum;
    logic                   div_done;
    logic [DATA_W-1:0]      div_quo;
    logic [DATA_W-1:0]      div_rem;

    // Handshake
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign fin_go   = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Register index decode
    assign a_in_range = ({1'b0, reg_a} < REG_LIMIT);
    assign b_in_range = ({1'b0, reg_b} < REG_LIMIT);
    assign addr_a     = reg_a[REG_ADDR_W-1:0];
    assign addr_b     = reg_b[REG_ADDR_W-1:0];
    assign wr_addr    = rb_reg[REG_ADDR_W-1:0];

    // Write back only a successful result to an existing register
    assign res_ok = (st_reg == ST_OK);
    assign wr_en  = fin_go && res_ok && rb_in_reg;

    // Shared 32x32 multiplier: low*low, low*high, high*low
    always_comb
    begin
        case (mul_step_reg)
            2'd1:
            begin
                mul_x = va_reg[HALF_W-1:0];
                mul_y = vb_reg[DATA_W-1:HALF_W];
            end
            2'd2:
            begin
                mul_x = va_reg[DATA_W-1:HALF_W];
                mul_y = vb_reg[HALF_W-1:0];
            end
            default:
            begin
                mul_x = va_reg[HALF_W-1:0];
                mul_y = vb_reg[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p   = DATA_W'(mul_x) * DATA_W'(mul_y);
    assign mul_sum = mul_acc_reg + {mul_prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    y86_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (vb_reg),
        .divisor   (va_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Register file: write back at finish, read both sources at acceptance
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= res_reg;
        end
        if (accept)
        begin
            rd_a_reg <= rf_mem[addr_a];
            rd_b_reg <= rf_mem[addr_b];
        end
    end

    // Sequencer, architectural state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            cc_zero_reg    <= 1'b0;
            cc_sign_reg    <= 1'b0;
            pc_reg         <= '0;
            valid_bits_reg <= '0;
            div_start_reg  <= 1'b0;
            mul_step_reg   <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    mul_step_reg <= '0;
                    if (pre_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        case (func_reg)
                            OP_MUL:
                            begin
                                state_reg <= S_MUL;
                            end
                            OP_DIV, OP_MOD:
                            begin
                                if (va_reg == '0)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    div_start_reg <= 1'b1;
                                    state_reg     <= S_DIV;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    mul_step_reg <= mul_step_reg + 1'b1;
                    if (mul_step_reg == 2'd3)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= S_IDLE;
                        if (wr_en)
                        begin
                            valid_bits_reg[wr_addr] <= 1'b1;
                        end
                        if (!pre_reg)
                        begin
                            cc_zero_reg <= res_ok && (res_reg == '0);
                            cc_sign_reg <= res_ok && res_reg[DATA_W-1];
                            if (res_ok)
                            begin
                                pc_reg <= npc_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Hold the result until taken
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        // Capture the transaction
        if (accept)
        begin
            func_reg  <= func;
            rb_reg    <= reg_b;
            rb_in_reg <= b_in_range;
            npc_reg   <= next_pc;
            pre_reg   <= preload;
            imm_reg   <= imm_value;
            a_ok_reg  <= a_in_range && valid_bits_reg[addr_a];
            b_ok_reg  <= b_in_range && valid_bits_reg[addr_b];
        end

        // Stage operands, unwritten or missing registers read as zero
        if (state_reg == S_LOAD)
        begin
            va_reg <= a_ok_reg ? rd_a_reg : '0;
            vb_reg <= b_ok_reg ? rd_b_reg : '0;
        end

        // Execute add, subtract, and, xor and preload, and decode errors
        if (state_reg == S_EXEC)
        begin
            st_reg  <= ST_OK;
            res_reg <= '0;
            if (pre_reg)
            begin
                res_reg <= imm_reg;
            end
            else
            begin
                case (func_reg)
                    OP_ADD: res_reg <= vb_reg + va_reg;
                    OP_SUB: res_reg <= vb_reg - va_reg;
                    OP_AND: res_reg <= vb_reg & va_reg;
                    OP_XOR: res_reg <= vb_reg ^ va_reg;
                    OP_MUL: res_reg <= '0;
                    OP_DIV, OP_MOD:
                    begin
                        if (va_reg == '0)
                        begin
                            st_reg <= ST_DIVZERO;
                        end
                    end
                    default: st_reg <= ST_INVALID;
                endcase
            end
        end

        // Accumulate partial products
        if (state_reg == S_MUL)
        begin
            mul_prod_reg <= mul_p;
            case (mul_step_reg)
                2'd1:    mul_acc_reg <= mul_prod_reg;
                2'd2:    mul_acc_reg <= mul_sum;
                2'd3:    res_reg     <= mul_sum;
                default: mul_acc_reg <= mul_acc_reg;
            endcase
        end

        // Take quotient or remainder
        if ((state_reg == S_DIV) && div_done)
        begin
            res_reg <= (func_reg == OP_DIV) ? div_quo : div_rem;
        end

        // Load the output register
        if (fin_go)
        begin
            result_value_reg <= wr_en ? res_reg : '0;
            status_out_reg   <= st_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign zero_flag    = cc_zero_reg;
    assign sign_flag    = cc_sign_reg;
    assign pc_value     = pc_reg;
    assign status       = status_out_reg;

endmodule

// ----- rtl/y86_checker.sv -----
// ----------------------------------------------------------------------------
// y86_checker
// Port-level checks for the ALU execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module y86_checker
    import y86_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_value,
    input logic        zero_flag,
    input logic        sign_flag,
    input logic [1:0]  status
);

    // One transaction in work: the input side closes right after acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction is in work");

    // A new result appears only while a transaction was in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no transaction in work");

    // Condition codes are exclusive
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(zero_flag && sign_flag))
        else $error("zero and sign flags both set");

    // A failed operation writes nothing and clears the flags
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INVALID || status == ST_DIVZERO))
        |-> (result_value == '0) && !zero_flag && !sign_flag)
        else $error("failed operation left a result or flags");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(result_value))
        else $error("stalled result changed");

endmodule

bind y86_alu_execute_unit y86_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .zero_flag    (zero_flag),
    .sign_flag    (sign_flag),
    .status       (status)
);
